>>> rtl/core/sgp_pkg.sv
// Shared constants and types for the spatial gain and pan block.
`default_nettype none
package sgp_pkg;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int GAIN_FRAC_DEF   = 15;
	localparam int OUT_W           = 16;
	localparam int RIGHT_W         = 16;
	localparam int CFG_IDX_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LIS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIS_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Z = 3'd5;

	localparam logic signed [RIGHT_W-1:0] RIGHT_X_RST = 16'sd32767;

	localparam logic [1:0] GK_FULL = 2'd0;
	localparam logic [1:0] GK_ZERO = 2'd1;
	localparam logic [1:0] GK_RAMP = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       sat;
		logic       neg;
		logic       zero;
	} sgp_flags_t;
endpackage
`default_nettype wire

>>> rtl/core/sgp_if.sv
// Source-position and result channels.
`default_nettype none
interface sgp_src_if import sgp_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] source_x;
	logic signed [COORD_WIDTH-1:0] source_y;
	logic signed [COORD_WIDTH-1:0] source_z;
	logic        [COORD_WIDTH-1:0] near_distance;
	logic        [COORD_WIDTH-1:0] far_distance;
	modport source (output valid, source_x, source_y, source_z, near_distance, far_distance,
		input ready);
	modport sink (input valid, source_x, source_y, source_z, near_distance, far_distance,
		output ready);
endinterface

interface sgp_res_if import sgp_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic        [OUT_W-1:0] gain;
	logic signed [OUT_W-1:0] pan;
	modport source (output valid, gain, pan, input ready);
	modport sink (input valid, gain, pan, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spatial_gain_and_pan.sv
// Top level: distance gain and stereo pan of a source against the listener.
//
//  channel  dir  handshake      payload
//  src      in   valid/ready    source_x/y/z, near_distance, far_distance
//  res      out  valid/ready    gain, pan
//  wr_*     in   wr_en          wr_idx, wr_data
//
// One word per cycle when not stalled; words pass the offset, square and sum stages,
// the square-root cell row (one root bit per cell), the setup stage and the divider rows.
// All stages move together; they halt only while the output register is full
// and res.ready is low. arst_n clears valids and config registers, but sets right-x to 32767.
`default_nettype none
module spatial_gain_and_pan import sgp_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	sgp_src_if.sink                     src,
	sgp_res_if.source                   res,
	input  wire logic                   wr_en,
	input  wire logic [CFG_IDX_W-1:0]   wr_idx,
	input  wire logic [COORD_WIDTH-1:0] wr_data
);
	localparam int CW    = COORD_WIDTH;
	localparam int G     = GAIN_FRAC_BITS;
	localparam int DW    = CW + 1;
	localparam int QW    = 2 * DW;
	localparam int SW    = QW + 2;
	localparam int RADW  = SW + 12;
	localparam int LW    = RADW / 2;
	localparam int DSTW  = LW - 6;
	localparam int PW    = DW + RIGHT_W;
	localparam int DPW   = PW + 2;
	localparam int NW    = DPW + 6;
	localparam int HIW   = NW - 16;
	localparam int DIVN  = (G > 16) ? G : 16;
	localparam int NST   = 4 + LW + DIVN;

	// configuration
	logic signed [CW-1:0]      lis_x_q, lis_y_q, lis_z_q;
	logic signed [RIGHT_W-1:0] rx_q, ry_q, rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lis_x_q <= '0;
			lis_y_q <= '0;
			lis_z_q <= '0;
			rx_q    <= RIGHT_X_RST;
			ry_q    <= '0;
			rz_q    <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_LIS_X:   lis_x_q <= wr_data;
				REG_LIS_Y:   lis_y_q <= wr_data;
				REG_LIS_Z:   lis_z_q <= wr_data;
				REG_RIGHT_X: rx_q    <= wr_data[RIGHT_W-1:0];
				REG_RIGHT_Y: ry_q    <= wr_data[RIGHT_W-1:0];
				REG_RIGHT_Z: rz_q    <= wr_data[RIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	logic           adv;
	logic [NST-1:0] vld_q;
	logic           out_vld_q;

	assign adv       = !out_vld_q || res.ready;
	assign src.ready = adv;
	assign res.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[NST-2:0], src.valid};
			out_vld_q <= vld_q[NST-1];
		end
	end

	// s1: offsets
	logic signed [DW-1:0] dx_c, dy_c, dz_c;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic        [DW-1:0] ax_s1, ay_s1, az_s1;
	logic        [CW-1:0] near_s1, far_s1;

	always_comb begin
		dx_c = DW'(src.source_x) - DW'(lis_x_q);
		dy_c = DW'(src.source_y) - DW'(lis_y_q);
		dz_c = DW'(src.source_z) - DW'(lis_z_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			dz_s1   <= dz_c;
			ax_s1   <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
			ay_s1   <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
			az_s1   <= dz_c[DW-1] ? DW'(-dz_c) : DW'(dz_c);
			near_s1 <= src.near_distance;
			far_s1  <= src.far_distance;
		end
	end

	// s2: squares and projections
	logic        [QW-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic signed [PW-1:0] prx_s2, pry_s2, prz_s2;
	logic        [CW-1:0] near_s2, far_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= QW'(ax_s1) * QW'(ax_s1);
			sqy_s2  <= QW'(ay_s1) * QW'(ay_s1);
			sqz_s2  <= QW'(az_s1) * QW'(az_s1);
			prx_s2  <= PW'(dx_s1) * PW'(rx_q);
			pry_s2  <= PW'(dy_s1) * PW'(ry_q);
			prz_s2  <= PW'(dz_s1) * PW'(rz_q);
			near_s2 <= near_s1;
			far_s2  <= far_s1;
		end
	end

	// s3: sums
	logic        [SW-1:0]  sum_s3;
	logic signed [DPW-1:0] dot_s3;
	logic        [CW-1:0]  near_s3, far_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= SW'(sqx_s2) + SW'(sqy_s2) + SW'(sqz_s2);
			dot_s3  <= DPW'(prx_s2) + DPW'(pry_s2) + DPW'(prz_s2);
			near_s3 <= near_s2;
			far_s3  <= far_s2;
		end
	end

	// square-root row
	logic        [RADW-1:0] rad_w  [LW+1];
	logic        [LW+1:0]   rem_w  [LW+1];
	logic        [LW-1:0]   root_w [LW+1];
	logic        [CW-1:0]   near_q [LW+1];
	logic        [CW-1:0]   far_q  [LW+1];
	logic signed [DPW-1:0]  dot_q  [LW+1];

	assign rad_w[0]  = {sum_s3, 12'b0};
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign near_q[0] = near_s3;
	assign far_q[0]  = far_s3;
	assign dot_q[0]  = dot_s3;

	for (genvar i = 0; i < LW; i++) begin : g_sqrt
		sgp_sqrt_cell #(.RADW(RADW), .LW(LW)) u_cell (
			.clk    (clk),
			.en     (adv),
			.rad_i  (rad_w[i]),
			.rem_i  (rem_w[i]),
			.root_i (root_w[i]),
			.rad_q  (rad_w[i+1]),
			.rem_q  (rem_w[i+1]),
			.root_q (root_w[i+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				near_q[i+1] <= near_q[i];
				far_q[i+1]  <= far_q[i];
				dot_q[i+1]  <= dot_q[i];
			end
		end
	end

	// s4: ramp and pan setup
	logic [LW-1:0]   len_c;
	logic [DSTW-1:0] dist_c;
	logic [DPW-1:0]  mag_c;
	logic [NW-1:0]   num_c;
	logic [HIW-1:0]  hi_c;
	sgp_flags_t      flg_c;

	logic [CW-1:0]   grem_s4, gden_s4;
	logic [LW-1:0]   prem_s4, pden_s4;
	logic [DIVN-1:0] plow_s4;
	sgp_flags_t      flg_s4;

	always_comb begin
		len_c  = root_w[LW];
		dist_c = len_c[LW-1:6];
		mag_c  = dot_q[LW][DPW-1] ? DPW'(-dot_q[LW]) : DPW'(dot_q[LW]);
		num_c  = {mag_c, 6'b0};
		hi_c   = num_c[NW-1:16];
		if (dist_c <= DSTW'(near_q[LW]))
			flg_c.kind = GK_FULL;
		else if (dist_c >= DSTW'(far_q[LW]))
			flg_c.kind = GK_ZERO;
		else
			flg_c.kind = GK_RAMP;
		flg_c.sat  = hi_c >= HIW'(len_c);
		flg_c.neg  = dot_q[LW][DPW-1];
		flg_c.zero = len_c == '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_s4  <= flg_c;
			grem_s4 <= (flg_c.kind == GK_RAMP) ? CW'(dist_c - DSTW'(near_q[LW])) : '0;
			gden_s4 <= far_q[LW] - near_q[LW];
			prem_s4 <= (flg_c.sat || flg_c.zero) ? '0 : LW'(hi_c);
			pden_s4 <= len_c;
			plow_s4 <= DIVN'(num_c[15:0]) << (DIVN - 16);
		end
	end

	// divider rows
	logic [CW-1:0]   grem_w [DIVN+1];
	logic [CW-1:0]   gden_w [DIVN+1];
	logic [DIVN-1:0] glow_w [DIVN+1];
	logic [DIVN-1:0] gq_w   [DIVN+1];
	logic [LW-1:0]   prem_w [DIVN+1];
	logic [LW-1:0]   pden_w [DIVN+1];
	logic [DIVN-1:0] plow_w [DIVN+1];
	logic [DIVN-1:0] pq_w   [DIVN+1];
	sgp_flags_t      flg_q  [DIVN+1];

	assign grem_w[0] = grem_s4;
	assign gden_w[0] = gden_s4;
	assign glow_w[0] = '0;
	assign gq_w[0]   = '0;
	assign prem_w[0] = prem_s4;
	assign pden_w[0] = pden_s4;
	assign plow_w[0] = plow_s4;
	assign pq_w[0]   = '0;
	assign flg_q[0]  = flg_s4;

	for (genvar j = 0; j < DIVN; j++) begin : g_div
		sgp_div_cell #(.W(CW), .NB(DIVN)) u_gain (
			.clk   (clk),
			.en    (adv),
			.rem_i (grem_w[j]),
			.den_i (gden_w[j]),
			.low_i (glow_w[j]),
			.q_i   (gq_w[j]),
			.rem_q (grem_w[j+1]),
			.den_q (gden_w[j+1]),
			.low_q (glow_w[j+1]),
			.q_q   (gq_w[j+1])
		);
		sgp_div_cell #(.W(LW), .NB(DIVN)) u_pan (
			.clk   (clk),
			.en    (adv),
			.rem_i (prem_w[j]),
			.den_i (pden_w[j]),
			.low_i (plow_w[j]),
			.q_i   (pq_w[j]),
			.rem_q (prem_w[j+1]),
			.den_q (pden_w[j+1]),
			.low_q (plow_w[j+1]),
			.q_q   (pq_w[j+1])
		);
		always_ff @(posedge clk) begin
			if (adv)
				flg_q[j+1] <= flg_q[j];
		end
	end

	// output register
	logic [G:0]        full_c, gainv_c;
	logic [DIVN-1:0]   qg_c, qp_c;
	logic [OUT_W:0]    pm_c;
	logic [OUT_W-1:0]  pan_c;
	logic [OUT_W-1:0]  gain_q, pan_q;
	sgp_flags_t        flo_c;

	always_comb begin
		flo_c  = flg_q[DIVN];
		full_c = (G+1)'(1) << G;
		qg_c   = gq_w[DIVN] >> (DIVN - G);
		qp_c   = pq_w[DIVN] >> (DIVN - OUT_W);
		case (flo_c.kind)
			GK_FULL: gainv_c = full_c;
			GK_RAMP: gainv_c = full_c - (G+1)'(qg_c);
			default: gainv_c = '0;
		endcase
		pm_c = flo_c.sat ? (OUT_W+1)'(1) << OUT_W : (OUT_W+1)'(qp_c);
		if (flo_c.zero)
			pan_c = '0;
		else if (flo_c.neg) begin
			if (pm_c > (OUT_W+1)'(1) << (OUT_W - 1))
				pm_c = (OUT_W+1)'(1) << (OUT_W - 1);
			pan_c = OUT_W'(((OUT_W+1)'(1) << OUT_W) - pm_c);
		end else begin
			if (pm_c > ((OUT_W+1)'(1) << (OUT_W - 1)) - 1'b1)
				pm_c = ((OUT_W+1)'(1) << (OUT_W - 1)) - 1'b1;
			pan_c = OUT_W'(pm_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gain_q <= OUT_W'(gainv_c);
			pan_q  <= pan_c;
		end
	end

	assign res.gain = gain_q;
	assign res.pan  = pan_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		src.valid && src.ready |=> vld_q[0])
		else $error("accepted word missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NST-1] && adv |=> res.valid)
		else $error("last stage word not loaded into output");
endmodule
`default_nettype wire

>>> rtl/core/sgp_sqrt_cell.sv
// One bit of the pipelined integer square root.
`default_nettype none
module sgp_sqrt_cell #(
	parameter int RADW = 64,
	parameter int LW   = 32
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [RADW-1:0] rad_i,
	input  wire logic [LW+1:0]   rem_i,
	input  wire logic [LW-1:0]   root_i,
	output logic      [RADW-1:0] rad_q,
	output logic      [LW+1:0]   rem_q,
	output logic      [LW-1:0]   root_q
);
	localparam int RW = LW + 2;

	logic [RW+1:0] t;
	logic [RW+1:0] trial;
	logic          ge;

	always_comb begin
		t     = {rem_i, rad_i[RADW-1 -: 2]};
		trial = (RW+2)'({root_i, 2'b01});
		ge    = t >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= rad_i << 2;
			rem_q  <= ge ? RW'(t - trial) : RW'(t);
			root_q <= {root_i[LW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/sgp_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module sgp_div_cell #(
	parameter int W  = 24,
	parameter int NB = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  rem_i,
	input  wire logic [W-1:0]  den_i,
	input  wire logic [NB-1:0] low_i,
	input  wire logic [NB-1:0] q_i,
	output logic      [W-1:0]  rem_q,
	output logic      [W-1:0]  den_q,
	output logic      [NB-1:0] low_q,
	output logic      [NB-1:0] q_q
);
	logic [W:0] t;
	logic       ge;

	always_comb begin
		t  = {rem_i, low_i[NB-1]};
		ge = t >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? W'(t - {1'b0, den_i}) : W'(t);
			den_q <= den_i;
			low_q <= low_i << 1;
			q_q   <= {q_i[NB-2:0], ge};
		end
	end
endmodule
`default_nettype wire
